>>> hw/rtl/descriptor_loop_tlv_parser_core_assert.svh
// Assertion macros shared by the descriptor loop parser RTL.
`ifndef DESCRIPTOR_LOOP_TLV_PARSER_CORE_ASSERT_SVH
`define DESCRIPTOR_LOOP_TLV_PARSER_CORE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define DLP_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("descriptor loop parser: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define DLP_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("descriptor loop parser: next-cycle check failed");

`endif

>>> hw/rtl/dlp_pkg.sv
// Shared types and constants of the descriptor loop parser.
package dlp_pkg;

   localparam int MaxLoopBytes = 4095;
   localparam int LenW = 12;
   localparam int BlW = $clog2(MaxLoopBytes + 1);
   localparam int CmpW = (BlW > 8) ? BlW : 8;
   localparam int CntW = 11;
   localparam int RoleW = 3;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;

   typedef logic [RoleW-1:0] role_type;
   localparam role_type RoleTag = 3'd0;
   localparam role_type RoleLen = 3'd1;
   localparam role_type RolePay = 3'd2;
   localparam role_type RoleDisc = 3'd3;
   localparam role_type RoleOut = 3'd4;

   typedef enum logic [3:0] {
      PhIdle = 4'b0001,
      PhTag  = 4'b0010,
      PhLen  = 4'b0100,
      PhPay  = 4'b1000
   } phase_type;

   typedef logic [CsrAddrW-1:0] csr_addr_type;
   localparam csr_addr_type CsrMatchTag = 3'd0;

   typedef struct packed {
      logic [7:0]      data_byte;
      logic            loop_start;
      logic [LenW-1:0] loop_length;
   } item_type;

   typedef struct packed {
      role_type        byte_role;
      logic [7:0]      desc_tag;
      logic [7:0]      desc_length;
      logic [7:0]      payload_offset;
      logic            desc_complete;
      logic            tag_match;
      logic            first_match_res;
      logic [CntW-1:0] desc_ordinal;
      logic [CntW-1:0] match_ordinal;
      logic            loop_done;
   } result_type;

endpackage

>>> hw/rtl/dlp_csr.sv
// Configuration register block holding the searched descriptor tag.
module dlp_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  dlp_pkg::csr_addr_type  csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output logic [7:0]             match_tag
);
   import dlp_pkg::*;

   logic [7:0] match_tag_ff;
   logic [7:0] match_tag_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign match_tag = match_tag_ff;

   always_comb begin
      match_tag_in = match_tag_ff;
      if (wr_en && (csr_paddr == CsrMatchTag)) begin
         match_tag_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_tag_ff <= '0;
      end else begin
         match_tag_ff <= match_tag_in;
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CsrMatchTag: csr_prdata = {{(CsrDataW - 8){1'b0}}, match_tag_ff};
         default:     csr_prdata = '0;
      endcase
   end

endmodule

>>> hw/rtl/dlp_parse.sv
// Parser state and the per-byte classification logic.
module dlp_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  dlp_pkg::item_type   item,
   input  logic [7:0]          match_tag,
   output dlp_pkg::result_type result
);
   import dlp_pkg::*;

   phase_type       phase_ff, phase_in;
   logic [BlW-1:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]      payload_left_ff, payload_left_in;
   logic [7:0]      current_tag_ff, current_tag_in;
   logic [7:0]      current_length_ff, current_length_in;
   logic [CntW-1:0] valid_count_ff, valid_count_in;
   logic [CntW-1:0] matched_count_ff, matched_count_in;
   logic            found_flag_ff, found_flag_in;

   phase_type       ph_e;
   logic [BlW-1:0]  bl_e;
   logic [7:0]      pl_e;
   logic [7:0]      ctag_e;
   logic [7:0]      clen_e;
   logic [CntW-1:0] vc_e;
   logic [CntW-1:0] mc_e;
   logic            ff_e;
   logic [BlW-1:0]  start_len;
   logic [7:0]      pl_dec;
   logic [7:0]      b;

   assign b = item.data_byte;

   always_comb begin
      if (32'(item.loop_length) > MaxLoopBytes) begin
         start_len = BlW'(MaxLoopBytes);
      end else begin
         start_len = BlW'(item.loop_length);
      end
   end

   always_comb begin
      if (item.loop_start) begin
         ph_e   = (start_len != '0) ? PhTag : PhIdle;
         bl_e   = start_len;
         pl_e   = '0;
         ctag_e = '0;
         clen_e = '0;
         vc_e   = '0;
         mc_e   = '0;
         ff_e   = 1'b0;
      end else begin
         ph_e   = phase_ff;
         bl_e   = bytes_left_ff;
         pl_e   = payload_left_ff;
         ctag_e = current_tag_ff;
         clen_e = current_length_ff;
         vc_e   = valid_count_ff;
         mc_e   = matched_count_ff;
         ff_e   = found_flag_ff;
      end
   end

   assign pl_dec = pl_e - 8'd1;

   always_comb begin
      phase_in          = ph_e;
      bytes_left_in     = bl_e;
      payload_left_in   = pl_e;
      current_tag_in    = ctag_e;
      current_length_in = clen_e;
      valid_count_in    = vc_e;
      matched_count_in  = mc_e;
      found_flag_in     = ff_e;
      result            = '0;
      result.byte_role  = RoleOut;

      if (bl_e != '0) begin
         unique case (ph_e)
            PhTag: begin
               if (bl_e < BlW'(2)) begin
                  result.byte_role = RoleDisc;
                  phase_in = PhIdle;
               end else begin
                  current_tag_in = b;
                  current_length_in = '0;
                  result.byte_role = RoleTag;
                  result.desc_tag = b;
                  phase_in = PhLen;
               end
            end
            PhLen: begin
               current_length_in = b;
               result.desc_tag = ctag_e;
               result.desc_length = b;
               if (CmpW'(b) >= CmpW'(bl_e)) begin
                  result.byte_role = RoleDisc;
                  phase_in = PhIdle;
               end else begin
                  result.byte_role = RoleLen;
                  if (b == 8'd0) begin
                     result.desc_complete = 1'b1;
                     phase_in = PhTag;
                  end else begin
                     payload_left_in = b;
                     phase_in = PhPay;
                  end
               end
            end
            PhPay: begin
               result.byte_role = RolePay;
               result.desc_tag = ctag_e;
               result.desc_length = clen_e;
               result.payload_offset = clen_e - pl_e;
               payload_left_in = pl_dec;
               if (pl_dec == 8'd0) begin
                  result.desc_complete = 1'b1;
                  phase_in = PhTag;
               end
            end
            default: begin
               result.byte_role = RoleDisc;
            end
         endcase

         if (result.desc_complete) begin
            result.desc_ordinal = vc_e;
            if (ctag_e == match_tag) begin
               result.tag_match = 1'b1;
               result.first_match_res = !ff_e;
               result.match_ordinal = mc_e;
               matched_count_in = mc_e + CntW'(1);
               found_flag_in = 1'b1;
            end
            valid_count_in = vc_e + CntW'(1);
         end

         bytes_left_in = bl_e - BlW'(1);
         if (bytes_left_in == '0) begin
            result.loop_done = 1'b1;
            phase_in = PhIdle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PhIdle;
         bytes_left_ff     <= '0;
         payload_left_ff   <= '0;
         current_tag_ff    <= '0;
         current_length_ff <= '0;
         valid_count_ff    <= '0;
         matched_count_ff  <= '0;
         found_flag_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff          <= phase_in;
         bytes_left_ff     <= bytes_left_in;
         payload_left_ff   <= payload_left_in;
         current_tag_ff    <= current_tag_in;
         current_length_ff <= current_length_in;
         valid_count_ff    <= valid_count_in;
         matched_count_ff  <= matched_count_in;
         found_flag_ff     <= found_flag_in;
      end
   end

endmodule

>>> hw/rtl/descriptor_loop_tlv_parser_core.sv
// Top level of the descriptor loop parser: request and response registers around the parser.
//
//   Channel   Direction   Handshake               Carries
//   req_      in          req_valid / req_stall   one loop byte with start flag and length
//   rsp_      out         rsp_valid / rsp_stall   classification of that byte
//   csr_      in/out      APB-style               match_tag at byte address 0
//
// Each request is registered, classified against the parser state and written to the
// response register, so a byte can be taken on every clock while no response is stalled.
// A response becomes valid once its request has passed the request and response registers.
// Reset is synchronous and clears the parser state, both valid flags and match_tag.
// A stalled response holds the request register; requests are stalled only then.
module descriptor_loop_tlv_parser_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_loop_start,
   input  logic [11:0]                 req_loop_length,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_byte_role,
   output logic [7:0]                  rsp_desc_tag,
   output logic [7:0]                  rsp_desc_length,
   output logic [7:0]                  rsp_payload_offset,
   output logic                        rsp_desc_complete,
   output logic                        rsp_tag_match,
   output logic                        rsp_first_match_res,
   output logic [10:0]                 rsp_desc_ordinal,
   output logic [10:0]                 rsp_match_ordinal,
   output logic                        rsp_loop_done,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import dlp_pkg::*;

   `include "descriptor_loop_tlv_parser_core_assert.svh"

   item_type   item_ff, item_in;
   logic       s1_valid_ff, s1_valid_in;
   result_type result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type parse_result;
   logic [7:0] match_tag;
   logic       out_free;
   logic       fire;

   dlp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .match_tag   (match_tag)
   );

   dlp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .match_tag (match_tag),
      .result    (parse_result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   always_comb begin
      item_in     = item_ff;
      s1_valid_in = s1_valid_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         item_in.data_byte = req_data_byte;
         item_in.loop_start = req_loop_start;
         item_in.loop_length = req_loop_length;
      end
   end

   always_comb begin
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (fire) begin
         result_in = parse_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_role       = result_ff.byte_role;
   assign rsp_desc_tag        = result_ff.desc_tag;
   assign rsp_desc_length     = result_ff.desc_length;
   assign rsp_payload_offset  = result_ff.payload_offset;
   assign rsp_desc_complete   = result_ff.desc_complete;
   assign rsp_tag_match       = result_ff.tag_match;
   assign rsp_first_match_res = result_ff.first_match_res;
   assign rsp_desc_ordinal    = result_ff.desc_ordinal;
   assign rsp_match_ordinal   = result_ff.match_ordinal;
   assign rsp_loop_done       = result_ff.loop_done;

   `DLP_ASSERT_SAME(a_stall_needs_item, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff)
   `DLP_ASSERT_NEXT(a_held_item_kept, clock, reset, s1_valid_ff && rsp_valid_ff && rsp_stall,
      s1_valid_ff && rsp_valid_ff)
   `DLP_ASSERT_SAME(a_match_is_complete, clock, reset, rsp_valid_ff && rsp_first_match_res,
      rsp_tag_match && rsp_desc_complete && (rsp_byte_role == RoleLen || rsp_byte_role == RolePay))

endmodule

>>> dv/descriptor_loop_tlv_parser_core_checker.sv
// Checker for the descriptor loop parser: predicts each response and compares it.
`timescale 1ns / 1ps

module descriptor_loop_tlv_parser_core_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_loop_start,
   input  logic [dlp_pkg::LenW-1:0] req_loop_length,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [2:0]               rsp_byte_role,
   input  logic [7:0]               rsp_desc_tag,
   input  logic [7:0]               rsp_desc_length,
   input  logic [7:0]               rsp_payload_offset,
   input  logic                     rsp_desc_complete,
   input  logic                     rsp_tag_match,
   input  logic                     rsp_first_match_res,
   input  logic [dlp_pkg::CntW-1:0] rsp_desc_ordinal,
   input  logic [dlp_pkg::CntW-1:0] rsp_match_ordinal,
   input  logic                     rsp_loop_done,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       pending
);
   import dlp_pkg::*;

   phase_type       ph;
   logic [LenW-1:0] bytes_left;
   logic [7:0]      pay_left;
   logic [7:0]      cur_tag;
   logic [7:0]      cur_len;
   logic [CntW-1:0] desc_cnt;
   logic [CntW-1:0] hit_cnt;
   logic            found;
   logic [7:0]      tag_sel;
   result_type      expected_bytes[$];
   int              mismatches;

   function automatic result_type classify_byte(input logic [7:0] b, input logic start,
                                                input logic [LenW-1:0] len);
      result_type      r;
      logic [LenW-1:0] rem;
      logic            ends;
      r = '0;
      r.byte_role = RoleOut;
      ends = 1'b0;
      if (start) begin
         bytes_left = (len > MaxLoopBytes) ? LenW'(MaxLoopBytes) : len;
         ph = (bytes_left != 0) ? PhTag : PhIdle;
         pay_left = '0;
         cur_tag = '0;
         cur_len = '0;
         desc_cnt = '0;
         hit_cnt = '0;
         found = 1'b0;
      end
      if (bytes_left != 0) begin
         rem = bytes_left;
         case (ph)
            PhTag: begin
               if (rem < 2) begin
                  r.byte_role = RoleDisc;
                  ph = PhIdle;
               end else begin
                  cur_tag = b;
                  cur_len = '0;
                  r.byte_role = RoleTag;
                  r.desc_tag = b;
                  ph = PhLen;
               end
            end
            PhLen: begin
               cur_len = b;
               r.desc_tag = cur_tag;
               r.desc_length = b;
               if ({4'd0, b} > rem - LenW'(1)) begin
                  r.byte_role = RoleDisc;
                  ph = PhIdle;
               end else begin
                  r.byte_role = RoleLen;
                  if (b == 8'd0) begin
                     ends = 1'b1;
                     ph = PhTag;
                  end else begin
                     pay_left = b;
                     ph = PhPay;
                  end
               end
            end
            PhPay: begin
               r.byte_role = RolePay;
               r.desc_tag = cur_tag;
               r.desc_length = cur_len;
               r.payload_offset = cur_len - pay_left;
               pay_left = pay_left - 8'd1;
               if (pay_left == 8'd0) begin
                  ends = 1'b1;
                  ph = PhTag;
               end
            end
            default: r.byte_role = RoleDisc;
         endcase
         if (ends) begin
            r.desc_complete = 1'b1;
            r.desc_ordinal = desc_cnt;
            if (cur_tag == tag_sel) begin
               r.tag_match = 1'b1;
               r.first_match_res = !found;
               r.match_ordinal = hit_cnt;
               hit_cnt = hit_cnt + CntW'(1);
               found = 1'b1;
            end
            desc_cnt = desc_cnt + CntW'(1);
         end
         bytes_left = rem - LenW'(1);
         if (bytes_left == 0) begin
            r.loop_done = 1'b1;
            ph = PhIdle;
         end
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] seen);
      $display("%0t: response %s: expected %0h, got %0h", $time, what, want, seen);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) flag_mismatch(what, want, seen);
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         ph = PhIdle;
         bytes_left = '0;
         pay_left = '0;
         cur_tag = '0;
         cur_len = '0;
         desc_cnt = '0;
         hit_cnt = '0;
         found = 1'b0;
         tag_sel = '0;
         mismatches = 0;
         expected_bytes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CsrMatchTag)
            tag_sel = csr_pwdata[7:0];
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               flag_mismatch("with no request outstanding", 32'(0), 32'(rsp_byte_role));
            end else begin
               want = expected_bytes.pop_front();
               check_field("byte_role", 32'(want.byte_role), 32'(rsp_byte_role));
               check_field("desc_tag", 32'(want.desc_tag), 32'(rsp_desc_tag));
               check_field("desc_length", 32'(want.desc_length), 32'(rsp_desc_length));
               check_field("payload_offset", 32'(want.payload_offset),
                           32'(rsp_payload_offset));
               check_field("desc_complete", 32'(want.desc_complete),
                           32'(rsp_desc_complete));
               check_field("tag_match", 32'(want.tag_match), 32'(rsp_tag_match));
               check_field("first_match_res", 32'(want.first_match_res),
                           32'(rsp_first_match_res));
               check_field("desc_ordinal", 32'(want.desc_ordinal), 32'(rsp_desc_ordinal));
               check_field("match_ordinal", 32'(want.match_ordinal),
                           32'(rsp_match_ordinal));
               check_field("loop_done", 32'(want.loop_done), 32'(rsp_loop_done));
            end
         end
         if (req_valid && !req_stall)
            expected_bytes.insert(expected_bytes.size(),
                                  classify_byte(req_data_byte, req_loop_start,
                                                req_loop_length));
      end
      pending <= expected_bytes.size();
      fail_count <= mismatches;
   end

endmodule

>>> dv/descriptor_loop_tlv_parser_core_tb.sv
// Testbench top for the descriptor loop parser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module descriptor_loop_tlv_parser_core_tb;
   import dlp_pkg::*;

   localparam int TimeoutCycles = 400000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   logic [7:0]      req_data_byte;
   logic            req_loop_start;
   logic [LenW-1:0] req_loop_length;
   logic            rsp_valid;
   logic            rsp_stall;
   logic [2:0]      rsp_byte_role;
   logic [7:0]      rsp_desc_tag;
   logic [7:0]      rsp_desc_length;
   logic [7:0]      rsp_payload_offset;
   logic            rsp_desc_complete;
   logic            rsp_tag_match;
   logic            rsp_first_match_res;
   logic [CntW-1:0] rsp_desc_ordinal;
   logic [CntW-1:0] rsp_match_ordinal;
   logic            rsp_loop_done;
   logic            csr_psel;
   logic            csr_penable;
   logic            csr_pwrite;
   logic [2:0]      csr_paddr;
   logic [31:0]     csr_pwdata;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   int        fail_count;
   int        pending;
   int        cycle_cnt;
   int        loop_bytes_sent;
   bit        send_calm;
   bit        accept_calm;
   logic [7:0] tag_now;

   descriptor_loop_tlv_parser_core dut (.*);

   descriptor_loop_tlv_parser_core_checker chk (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == TimeoutCycles) begin
         $display("descriptor_loop_tlv_parser_core_tb: done, errors");
         $finish;
      end
   end

   function automatic int draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // The receiving side stalls for a drawn number of cycles before each response.
   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      accept_calm = 1'b0;
      forever begin
         if ($urandom_range(0, 39) == 0) accept_calm = !accept_calm;
         n = draw_wait(accept_calm);
         repeat (n) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic start,
                            input logic [LenW-1:0] len);
      int n;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      n = draw_wait(send_calm);
      repeat (n) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data_byte = b;
      req_loop_start = start;
      req_loop_length = len;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_match_tag(input logic [7:0] tag);
      logic [31:0] w;
      w = $urandom;
      w[7:0] = tag;
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CsrMatchTag;
      csr_pwdata = w;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      tag_now = tag;
   endtask

   // Builds a loop of descriptors, with the odd overlong one and at times a lone trailing
   // byte, and sends at most stop_after of its bytes.
   task automatic send_loop(input int total, input int stop_after);
      logic [7:0] body[$];
      int         room;
      int         plen;
      if (total == 0) begin
         send_byte(8'($urandom_range(0, 255)), 1'b1, '0);
         loop_bytes_sent++;
      end else begin
         while (body.size() < total) begin
            room = total - body.size();
            if (room == 1) begin
               body.insert(body.size(), 8'($urandom_range(0, 255)));
            end else begin
               body.insert(body.size(),
                           $urandom_range(0, 1) ? tag_now : 8'($urandom_range(0, 255)));
               if ($urandom_range(0, 9) == 0)
                  plen = $urandom_range(0, 255);
               else if ($urandom_range(0, 7) == 0)
                  plen = 0;
               else
                  plen = $urandom_range(0, (room - 2 < 12) ? room - 2 : 12);
               body.insert(body.size(), 8'(plen));
               repeat (plen)
                  if (body.size() < total)
                     body.insert(body.size(), 8'($urandom_range(0, 255)));
            end
         end
         for (int i = 0; i < total && i < stop_after; i++) begin
            send_byte(body[i], i == 0, (i == 0) ? LenW'(total) : LenW'($urandom));
            loop_bytes_sent++;
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0] tag_plan[4];
      int         kind;
      int         total;
      cycle_cnt = 0;
      loop_bytes_sent = 0;
      send_calm = 1'b0;
      tag_now = 8'h00;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_loop_start = 1'b0;
      req_loop_length = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Bytes outside a loop and an empty loop.
      send_byte(8'hFF, 1'b0, 12'hFFF);
      send_byte(8'hAA, 1'b1, 12'h000);
      send_byte(8'h00, 1'b0, 12'h000);
      // Matching descriptors, one of zero length, then a lone trailing byte.
      send_byte(8'h00, 1'b1, 12'd7);
      send_byte(8'h02, 1'b0, 12'h000);
      send_byte(8'hFF, 1'b0, 12'h000);
      send_byte(8'h00, 1'b0, 12'h000);
      send_byte(8'h00, 1'b0, 12'h000);
      send_byte(8'h00, 1'b0, 12'h000);
      send_byte(8'h5A, 1'b0, 12'h000);
      // A descriptor too long for its loop.
      send_byte(8'h47, 1'b1, 12'd5);
      send_byte(8'hC8, 1'b0, 12'h000);
      send_byte(8'h01, 1'b0, 12'h000);
      send_byte(8'h02, 1'b0, 12'h000);
      send_byte(8'h03, 1'b0, 12'h000);
      // A full-size loop abandoned by a new loop start.
      send_byte(8'h12, 1'b1, 12'hFFF);
      send_byte(8'h03, 1'b0, 12'h000);
      send_byte(8'h00, 1'b1, 12'd3);
      send_byte(8'h01, 1'b0, 12'h000);
      send_byte(8'hFF, 1'b0, 12'h000);
      wait_quiet();
      write_match_tag(8'h47);
      send_byte(8'h47, 1'b1, 12'd4);
      send_byte(8'h00, 1'b0, 12'h000);
      send_byte(8'h47, 1'b0, 12'h000);
      send_byte(8'h00, 1'b0, 12'h000);

      tag_plan[0] = 8'hFF;
      tag_plan[1] = 8'($urandom_range(0, 255));
      tag_plan[2] = 8'h00;
      tag_plan[3] = 8'($urandom_range(0, 255));
      for (int p = 0; p < 4; p++) begin
         wait_quiet();
         write_match_tag(tag_plan[p]);
         if (p == 2) send_loop(600, 600);
         while (loop_bytes_sent < (p + 1) * 275) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
               send_byte(8'($urandom_range(0, 255)), 1'b0, LenW'($urandom));
            end else if (kind == 1) begin
               send_loop(0, 1);
            end else if (kind == 2) begin
               total = $urandom_range(2, 60);
               send_loop(total, $urandom_range(1, total - 1));
            end else if (kind == 3) begin
               send_loop($urandom_range(0, 4095), $urandom_range(1, 8));
            end else begin
               send_loop($urandom_range(1, 40), 4096);
            end
            if ($urandom_range(0, 24) == 0) wait_quiet();
         end
      end

      wait_quiet();
      if (fail_count == 0)
         $display("descriptor_loop_tlv_parser_core_tb: done, clean");
      else
         $display("descriptor_loop_tlv_parser_core_tb: done, errors");
      $finish;
   end

endmodule
